// ===== src/owbm_pkg.sv =====
package owbm_pkg;

  localparam int unsigned CmdW      = 2;
  localparam int unsigned LongTickW = 10;
  localparam int unsigned ShortTickW = 8;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned BitIdxW   = 3;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 10;

  typedef enum logic [CmdW-1:0] {
    CMD_NONE  = 2'd0,
    CMD_RESET = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_RST_LOW  = 3'd1,
    PH_RST_WAIT = 3'd2,
    PH_RST_REC  = 3'd3,
    PH_SLOT     = 3'd4
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_RESET_LOW   = 3'd0,
    REG_PRES_SAMPLE = 3'd1,
    REG_RESET_REC   = 3'd2,
    REG_ZERO_LOW    = 3'd3,
    REG_SHORT_LOW   = 3'd4,
    REG_READ_SAMPLE = 3'd5,
    REG_SLOT        = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [LongTickW-1:0]  reset_low_ticks;
    logic [LongTickW-1:0]  presence_sample_ticks;
    logic [LongTickW-1:0]  reset_recover_ticks;
    logic [ShortTickW-1:0] zero_low_ticks;
    logic [ShortTickW-1:0] short_low_ticks;
    logic [ShortTickW-1:0] read_sample_ticks;
    logic [ShortTickW-1:0] slot_ticks;
  } cfg_t;

  typedef struct packed {
    logic [ByteW-1:0] received_byte;
    logic             presence;
    logic             done_res;
    logic             busy_res;
    logic             drive_low;
  } result_t;

endpackage

// ===== src/owbm_engine.sv =====
module owbm_engine #(
  parameter int unsigned BITS_PER_BYTE = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  owbm_pkg::cfg_t                     cfg_i,
  input  logic                               step_i,
  input  logic [owbm_pkg::CmdW-1:0]          command_i,
  input  logic [owbm_pkg::ByteW-1:0]         byte_to_send_i,
  input  logic                               line_level_i,
  output owbm_pkg::result_t                  result_o
);
  import owbm_pkg::*;

  localparam logic [BitIdxW:0] BitsLast = (BitIdxW+1)'(BITS_PER_BYTE);

  phase_e               phase_q, phase_d;
  logic [LongTickW-1:0] tick_q, tick_d;
  logic [BitIdxW-1:0]   bit_q, bit_d;
  logic [ByteW-1:0]     shift_q, shift_d;
  cmd_e                 active_q, active_d;
  logic                 presence_q, presence_d;
  logic [ByteW-1:0]     received_q, received_d;

  logic [LongTickW:0]    tick_inc;
  logic [ShortTickW-1:0] slot_last;
  logic [ShortTickW-1:0] low_len;
  logic [ShortTickW:0]   sample_pt;
  logic                  reading;

  always_comb begin
    phase_d    = phase_q;
    tick_d     = tick_q;
    bit_d      = bit_q;
    shift_d    = shift_q;
    active_d   = active_q;
    presence_d = presence_q;
    received_d = received_q;
    result_o   = '0;

    // a command is taken only when idle and runs its first tick right away
    if (phase_q == PH_IDLE && cmd_e'(command_i) != CMD_NONE) begin
      active_d = cmd_e'(command_i);
      tick_d   = '0;
      bit_d    = '0;
      if (cmd_e'(command_i) == CMD_RESET) begin
        phase_d = PH_RST_LOW;
      end else begin
        phase_d = PH_SLOT;
        shift_d = (cmd_e'(command_i) == CMD_WRITE) ? byte_to_send_i : '0;
      end
    end

    tick_inc  = {1'b0, tick_d} + (LongTickW+1)'(1);
    slot_last = (cfg_i.slot_ticks > ShortTickW'(1)) ?
                cfg_i.slot_ticks - ShortTickW'(1) : '0;
    reading   = (active_d == CMD_READ);
    low_len   = (reading || shift_d[0]) ? cfg_i.short_low_ticks : cfg_i.zero_low_ticks;
    sample_pt = {1'b0, cfg_i.short_low_ticks} + {1'b0, cfg_i.read_sample_ticks};
    if (sample_pt > {1'b0, slot_last}) begin
      sample_pt = {1'b0, slot_last};
    end

    if (phase_d != PH_IDLE) begin
      result_o.busy_res = 1'b1;
    end

    unique case (phase_d)
      PH_IDLE: ;
      PH_RST_LOW: begin
        result_o.drive_low = 1'b1;
        if (tick_inc >= {1'b0, cfg_i.reset_low_ticks}) begin
          phase_d = PH_RST_WAIT;
          tick_d  = '0;
        end else begin
          tick_d = tick_inc[LongTickW-1:0];
        end
      end
      PH_RST_WAIT: begin
        if (tick_d >= cfg_i.presence_sample_ticks) begin
          presence_d = ~line_level_i;
          phase_d    = PH_RST_REC;
          tick_d     = '0;
        end else begin
          tick_d = tick_inc[LongTickW-1:0];
        end
      end
      PH_RST_REC: begin
        if (tick_inc >= {1'b0, cfg_i.reset_recover_ticks}) begin
          result_o.done_res = 1'b1;
          phase_d  = PH_IDLE;
          tick_d   = '0;
          bit_d    = '0;
          active_d = CMD_NONE;
        end else begin
          tick_d = tick_inc[LongTickW-1:0];
        end
      end
      PH_SLOT: begin
        result_o.drive_low = (tick_d < LongTickW'(low_len));
        if (reading && tick_d == LongTickW'(sample_pt)) begin
          shift_d = {line_level_i, shift_d[ByteW-1:1]};
        end
        if (tick_d >= LongTickW'(slot_last)) begin
          if (!reading) begin
            shift_d = {1'b0, shift_d[ByteW-1:1]};
          end
          if ({1'b0, bit_d} + (BitIdxW+1)'(1) >= BitsLast) begin
            if (reading) begin
              received_d = shift_d;
            end
            result_o.done_res = 1'b1;
            phase_d  = PH_IDLE;
            tick_d   = '0;
            bit_d    = '0;
            active_d = CMD_NONE;
          end else begin
            bit_d  = bit_d + BitIdxW'(1);
            tick_d = '0;
          end
        end else begin
          tick_d = tick_inc[LongTickW-1:0];
        end
      end
      default: phase_d = PH_IDLE;
    endcase

    result_o.presence      = presence_d;
    result_o.received_byte = received_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      tick_q     <= '0;
      bit_q      <= '0;
      shift_q    <= '0;
      active_q   <= CMD_NONE;
      presence_q <= 1'b0;
      received_q <= '0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      tick_q     <= tick_d;
      bit_q      <= bit_d;
      shift_q    <= shift_d;
      active_q   <= active_d;
      presence_q <= presence_d;
      received_q <= received_d;
    end
  end

endmodule

// ===== src/one_wire_bus_master_top.sv =====
// 1-wire bus master timed by its input stream: each accepted transaction is one
// microsecond tick carrying the sampled bus level and, when the master is idle,
// a command (reset with presence detect, write byte, read byte, LSB first).
// Every tick yields exactly one result transaction with the line drive, busy,
// done, presence flag and the last received byte. One tick is taken per clock
// cycle: the engine state advances in a single registered step, and a result
// register decouples the output, so the input stays ready while the result
// register is empty or being taken. Timing registers are written through the
// config channel by the user only while no command is running; the block does not check.
module one_wire_bus_master_top #(
  parameter int unsigned BITS_PER_BYTE = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // config write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [owbm_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [owbm_pkg::CfgDataW-1:0]   cfg_data_i,
  // tick input
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [15:0]                     s_axis_tdata, // byte_to_send[7:0], line_level[8]
  input  logic [owbm_pkg::CmdW-1:0]       s_axis_tuser, // command[1:0]
  // tick result
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [15:0]                     m_axis_tdata  // drive_low[0], busy_res[1],
                                                        // done_res[2], presence[3],
                                                        // received_byte[11:4]
);
  import owbm_pkg::*;

  cfg_t    cfg_q;
  result_t res_d, res_q;
  logic    out_valid_q;
  logic    in_take;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = ~out_valid_q | m_axis_tready;
  assign in_take       = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low_ticks       <= LongTickW'(480);
      cfg_q.presence_sample_ticks <= LongTickW'(70);
      cfg_q.reset_recover_ticks   <= LongTickW'(410);
      cfg_q.zero_low_ticks        <= ShortTickW'(60);
      cfg_q.short_low_ticks       <= ShortTickW'(6);
      cfg_q.read_sample_ticks     <= ShortTickW'(9);
      cfg_q.slot_ticks            <= ShortTickW'(70);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (reg_idx_e'(cfg_index_i))
        REG_RESET_LOW:   cfg_q.reset_low_ticks       <= cfg_data_i;
        REG_PRES_SAMPLE: cfg_q.presence_sample_ticks <= cfg_data_i;
        REG_RESET_REC:   cfg_q.reset_recover_ticks   <= cfg_data_i;
        REG_ZERO_LOW:    cfg_q.zero_low_ticks        <= cfg_data_i[ShortTickW-1:0];
        REG_SHORT_LOW:   cfg_q.short_low_ticks       <= cfg_data_i[ShortTickW-1:0];
        REG_READ_SAMPLE: cfg_q.read_sample_ticks     <= cfg_data_i[ShortTickW-1:0];
        REG_SLOT:        cfg_q.slot_ticks            <= cfg_data_i[ShortTickW-1:0];
        default: ;
      endcase
    end
  end

  owbm_engine #(
    .BITS_PER_BYTE(BITS_PER_BYTE)
  ) u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .step_i        (in_take),
    .command_i     (s_axis_tuser),
    .byte_to_send_i(s_axis_tdata[ByteW-1:0]),
    .line_level_i  (s_axis_tdata[ByteW]),
    .result_o      (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_take) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, res_q};

`ifndef NO_ASSERTIONS
  // a finishing tick is always part of a command
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (!res_q.done_res || res_q.busy_res))
    else $error("done without busy");

  // the line is only pulled low while a command runs
  a_drive_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (!res_q.drive_low || res_q.busy_res))
    else $error("drive low while idle");

  // a new result is only loaded when the previous one has left
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> (out_valid_q && $stable(res_q)))
    else $error("result register overwritten");
`endif

endmodule

// ===== test/tb.sv =====
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import owbm_pkg::*;

  localparam int unsigned BitsPerByte = 8;
  localparam int unsigned LongHold    = 300;
  localparam int unsigned IdleLimit   = 4000;
  localparam int unsigned RandomTicks = 50;

  // how the bus line behaves while a command runs
  localparam int LINE_LOW    = 0;
  localparam int LINE_HIGH   = 1;
  localparam int LINE_RANDOM = 2;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] data;
    logic       line;
  } tick_t;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;

  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  reg_idx_e    cfg_index = REG_RESET_LOW;
  logic [9:0]  cfg_data  = '0;

  logic        s_valid = 1'b0;
  logic        s_ready;
  tick_t       cur_tick = '0;
  logic [15:0] s_data;
  logic [1:0]  s_user;

  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [15:0] m_data;

  // sampled line level and data byte travel in tdata, the command in tuser
  assign s_data = {7'b0, cur_tick.line, cur_tick.data};
  assign s_user = cur_tick.cmd;

  one_wire_bus_master_top #(
    .BITS_PER_BYTE(BitsPerByte)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_ready),
    .s_axis_tdata (s_data),
    .s_axis_tuser (s_user),
    .m_axis_tvalid(m_valid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_data)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  tick_t   tick_q[$];
  result_t tick_results_q[$];
  int      mismatches      = 0;
  int      sender_idle_pct = 0;
  int      stall_pct       = 0;
  int      hold_requests   = 0;

  // bus master copy: timing registers and engine state
  cfg_t timing = '{reset_low_ticks: 10'd480, presence_sample_ticks: 10'd70,
                   reset_recover_ticks: 10'd410, zero_low_ticks: 8'd60,
                   short_low_ticks: 8'd6, read_sample_ticks: 8'd9, slot_ticks: 8'd70};
  phase_e     ow_phase    = PH_IDLE;
  cmd_e       ow_cmd      = CMD_NONE;
  logic [9:0] ow_cnt      = '0;
  logic [2:0] ow_bit      = '0;
  logic [7:0] ow_shift    = '0;
  logic       ow_presence = 1'b0;
  logic [7:0] ow_received = '0;

  function automatic result_t one_wire_tick(cmd_e cmd, logic [7:0] data, logic line);
    result_t     r;
    int unsigned last;
    int unsigned low_len;
    int unsigned sample_at;
    logic        reading;
    logic        finished;
    r = '0;
    finished = 1'b0;
    if (ow_phase == PH_IDLE && cmd != CMD_NONE) begin
      ow_cmd = cmd;
      ow_cnt = '0;
      ow_bit = '0;
      if (cmd == CMD_RESET) begin
        ow_phase = PH_RST_LOW;
      end else begin
        ow_phase = PH_SLOT;
        ow_shift = (cmd == CMD_WRITE) ? data : 8'h00;
      end
    end
    if (ow_phase != PH_IDLE) begin
      r.busy_res = 1'b1;
      case (ow_phase)
        PH_RST_LOW: begin
          r.drive_low = 1'b1;
          if (32'(ow_cnt) + 1 >= 32'(timing.reset_low_ticks)) begin
            ow_phase = PH_RST_WAIT;
            ow_cnt   = '0;
          end else ow_cnt = ow_cnt + 1'b1;
        end
        PH_RST_WAIT: begin
          if (ow_cnt >= timing.presence_sample_ticks) begin
            ow_presence = ~line;
            ow_phase    = PH_RST_REC;
            ow_cnt      = '0;
          end else ow_cnt = ow_cnt + 1'b1;
        end
        PH_RST_REC: begin
          if (32'(ow_cnt) + 1 >= 32'(timing.reset_recover_ticks)) finished = 1'b1;
          else ow_cnt = ow_cnt + 1'b1;
        end
        PH_SLOT: begin
          last    = (timing.slot_ticks > 8'd1) ? 32'(timing.slot_ticks) - 1 : 0;
          reading = (ow_cmd == CMD_READ);
          if (reading || ow_shift[0]) low_len = 32'(timing.short_low_ticks);
          else low_len = 32'(timing.zero_low_ticks);
          if (32'(ow_cnt) < low_len) r.drive_low = 1'b1;
          if (reading) begin
            // read point clipped to the last tick of the slot
            sample_at = 32'(timing.short_low_ticks) + 32'(timing.read_sample_ticks);
            if (sample_at > last) sample_at = last;
            if (32'(ow_cnt) == sample_at) ow_shift = {line, ow_shift[7:1]};
          end
          if (32'(ow_cnt) >= last) begin
            if (!reading) ow_shift = ow_shift >> 1;
            if (32'(ow_bit) + 1 >= BitsPerByte) begin
              if (reading) ow_received = ow_shift;
              finished = 1'b1;
            end else begin
              ow_bit = ow_bit + 1'b1;
              ow_cnt = '0;
            end
          end else ow_cnt = ow_cnt + 1'b1;
        end
        default: ow_phase = PH_IDLE;
      endcase
      if (finished) begin
        r.done_res = 1'b1;
        ow_phase   = PH_IDLE;
        ow_cnt     = '0;
        ow_bit     = '0;
        ow_cmd     = CMD_NONE;
      end
    end
    r.presence      = ow_presence;
    r.received_byte = ow_received;
    return r;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // tick sender
  always @(posedge clk_i or negedge rst_ni) begin : tick_sender
    tick_t nxt;
    if (!rst_ni) begin
      s_valid <= 1'b0;
    end else begin
      if (s_valid && s_ready)
        tick_results_q.push_back(one_wire_tick(cur_tick.cmd, cur_tick.data, cur_tick.line));
      if (!s_valid || s_ready) begin
        if (tick_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          nxt = tick_q.pop_front();
          cur_tick <= nxt;
          s_valid  <= 1'b1;
        end else s_valid <= 1'b0;
      end
    end
  end

  // result receiver and checker
  int unsigned hold_left   = 0;
  int          hold_served = 0;

  always @(posedge clk_i or negedge rst_ni) begin : result_receiver
    result_t got;
    result_t want;
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      if (m_valid && m_ready) begin
        got = result_t'(m_data[$bits(result_t)-1:0]);
        if (tick_results_q.size() == 0) begin
          $error("result transaction with nothing expected: %h", m_data);
          mismatches++;
        end else begin
          want = tick_results_q.pop_front();
          check_field("drive_low", 8'(want.drive_low), 8'(got.drive_low));
          check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
          check_field("done_res", 8'(want.done_res), 8'(got.done_res));
          check_field("presence", 8'(want.presence), 8'(got.presence));
          check_field("received_byte", want.received_byte, got.received_byte);
        end
      end
      if (hold_served != hold_requests) begin
        hold_served <= hold_requests;
        hold_left   <= LongHold;
        m_ready     <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_ready   <= 1'b0;
      end else m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= IdleLimit) begin
        $display("*** FAILED ***");
        $finish;
      end else quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [9:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_RESET_LOW:   timing.reset_low_ticks       = val;
      REG_PRES_SAMPLE: timing.presence_sample_ticks = val;
      REG_RESET_REC:   timing.reset_recover_ticks   = val;
      REG_ZERO_LOW:    timing.zero_low_ticks        = val[7:0];
      REG_SHORT_LOW:   timing.short_low_ticks       = val[7:0];
      REG_READ_SAMPLE: timing.read_sample_ticks     = val[7:0];
      REG_SLOT:        timing.slot_ticks            = val[7:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic load_timing(logic [9:0] rst_low, logic [9:0] pres, logic [9:0] rec,
                             logic [9:0] zero_low, logic [9:0] short_low,
                             logic [9:0] rd_sample, logic [9:0] slot);
    write_reg(REG_RESET_LOW, rst_low);
    write_reg(REG_PRES_SAMPLE, pres);
    write_reg(REG_RESET_REC, rec);
    write_reg(REG_ZERO_LOW, zero_low);
    write_reg(REG_SHORT_LOW, short_low);
    write_reg(REG_READ_SAMPLE, rd_sample);
    write_reg(REG_SLOT, slot);
  endtask

  // one command, followed by busy ticks that carry ignored commands half the time
  task automatic send_command(cmd_e cmd, logic [7:0] data, int line_mode);
    int unsigned n;
    logic        line;
    cmd_e        noise;
    if (cmd == CMD_RESET)
      n = ((timing.reset_low_ticks > 10'd1) ? 32'(timing.reset_low_ticks) : 1)
          + 32'(timing.presence_sample_ticks) + 1
          + ((timing.reset_recover_ticks > 10'd1) ? 32'(timing.reset_recover_ticks) : 1);
    else n = BitsPerByte * ((timing.slot_ticks > 8'd1) ? 32'(timing.slot_ticks) : 1);
    for (int unsigned i = 0; i < n; i++) begin
      line  = (line_mode == LINE_RANDOM) ? 1'($urandom) : (line_mode == LINE_HIGH);
      noise = ($urandom_range(0, 1) != 0) ? cmd_e'($urandom_range(0, 3)) : CMD_NONE;
      tick_q.push_back('{cmd: (i == 0) ? cmd : noise, data: (i == 0) ? data : 8'($urandom),
                         line: line});
    end
  endtask

  // drain everything, then idle ticks until no command is running
  task automatic settle();
    forever begin
      while (tick_q.size() != 0 || s_valid || tick_results_q.size() != 0) @(negedge clk_i);
      if (ow_phase == PH_IDLE) break;
      repeat (4) tick_q.push_back('{cmd: CMD_NONE, data: 8'($urandom), line: 1'($urandom)});
    end
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // short but distinct timing, commands back to back
    load_timing(10'd6, 10'd3, 10'd5, 10'd3, 10'd1, 10'd1, 10'd4);
    send_command(CMD_RESET, 8'h00, LINE_LOW);
    tick_q.push_back('{cmd: CMD_NONE, data: 8'h5A, line: 1'b1});
    send_command(CMD_WRITE, 8'hA5, LINE_RANDOM);
    send_command(CMD_READ, 8'h00, LINE_HIGH);
    send_command(CMD_RESET, 8'hFF, LINE_HIGH);
    settle();

    // every stage collapsed to a single tick
    sender_idle_pct <= 10;
    stall_pct       <= 10;
    load_timing(10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
    send_command(CMD_RESET, 8'h00, LINE_LOW);
    send_command(CMD_RESET, 8'h00, LINE_HIGH);
    send_command(CMD_WRITE, 8'h00, LINE_RANDOM);
    send_command(CMD_WRITE, 8'hFF, LINE_RANDOM);
    send_command(CMD_READ, 8'hFF, LINE_LOW);
    send_command(CMD_READ, 8'h00, LINE_RANDOM);
    settle();

    // low pulses not shorter than a one-tick slot, late presence sample
    load_timing(10'd1, 10'd20, 10'd1, 10'd255, 10'd255, 10'd255, 10'd1);
    send_command(CMD_WRITE, 8'h3C, LINE_RANDOM);
    send_command(CMD_READ, 8'h00, LINE_RANDOM);
    send_command(CMD_RESET, 8'h00, LINE_LOW);
    settle();

    // zero pulse covers the slot, read point past the slot end
    load_timing(10'd2, 10'd1, 10'd2, 10'd200, 10'd2, 10'd255, 10'd5);
    send_command(CMD_READ, 8'h00, LINE_RANDOM);
    send_command(CMD_WRITE, 8'($urandom), LINE_RANDOM);
    settle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin sender_idle_pct <= 0;  stall_pct <= 0;  end
        1: begin sender_idle_pct <= 72; stall_pct <= 0;  end
        2: begin sender_idle_pct <= 0;  stall_pct <= 72; end
        default: begin sender_idle_pct <= 10; stall_pct <= 10; end
      endcase
      // short timing so that many commands fit; upper bits of byte-wide registers are junk
      load_timing(10'($urandom_range(0, 12)), 10'($urandom_range(0, 12)),
                  10'($urandom_range(0, 12)),
                  {2'($urandom_range(0, 3)), 8'($urandom_range(0, 6))},
                  {2'($urandom_range(0, 3)), 8'($urandom_range(0, 6))},
                  {2'($urandom_range(0, 3)), 8'($urandom_range(0, 6))},
                  {2'($urandom_range(0, 3)), 8'($urandom_range(0, 6))});
      repeat (RandomTicks)
        tick_q.push_back('{cmd: ($urandom_range(0, 9) < 3) ? cmd_e'($urandom_range(0, 3))
                                                           : CMD_NONE,
                           data: 8'($urandom), line: 1'($urandom)});
      // long receiver hold while ticks keep coming
      if (ph == 0) hold_requests <= hold_requests + 1;
      settle();
    end

    repeat (20) @(negedge clk_i);
    if (tick_results_q.size() != 0) begin
      $error("%0d expected results never arrived", tick_results_q.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
